// ----- sv/text_console_cell_writer_top_macros.svh -----
// Assertion macros for the text console cell writer.
`ifndef TEXT_CONSOLE_CELL_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCCW_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tccw_pkg.sv -----
// Constants and types shared by the text console cell writer.
package tccw_pkg;

	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int TAB_STOP    = 8;
	localparam int CELL_COUNT  = ROWS * COLUMNS;
	localparam int SHIFT_COUNT = (ROWS - 1) * COLUMNS;

	localparam int ADDR_W    = $clog2(CELL_COUNT);
	localparam int ROW_W     = $clog2(ROWS + 1);
	localparam int COL_W     = $clog2(COLUMNS + TAB_STOP);
	localparam int ROW_OUT_W = 5;
	localparam int COL_OUT_W = 7;
	localparam int CHAR_W    = 8;
	localparam int COLOR_W   = 8;
	localparam int CELL_W    = 16;
	localparam int INDEX_W   = 11;
	localparam int CMD_W     = 2;

	typedef logic [CELL_W-1:0] cell_t;

	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h0F;
	localparam logic [CHAR_W-1:0]  SPACE_CHAR  = 8'h20;
	localparam logic [CHAR_W-1:0]  CHAR_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0]  CHAR_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0]  CHAR_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0]  CHAR_LAST   = 8'h7F;

	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

endpackage

// ----- sv/text_console_cell_writer_top.sv -----
// Text console cell writer: screen store, cursor and put/clear/read sequencer.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, command, char_code,   | beat in
//          | cell_index                                |
//  out     | out_valid, out_stall, cell_value,         | beat out
//          | cursor_row_out, cursor_col_out            |
//  cfg     | cfg_wr_en, cfg_wr_data (text_color)       | write only
//
// Put without scroll and unused command: accept, then execute (via DONE if out_stall holds a result).
// Read: accept, execute, then DONE, which waits for the registered store read port.
// Clear fills every cell with spaces in text_color; scroll shifts the rows up and fills the last row,
// both through the single write port of the screen store, one cell at a time.
// After reset the store is swept with spaces in color 0x0F, with in_stall high.
// A result waiting on out_stall lets the next input beat be accepted, but that beat waits until the result is taken.
`include "text_console_cell_writer_top_macros.svh"

module text_console_cell_writer_top
	import tccw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CMD_W-1:0]     command,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [INDEX_W-1:0]   cell_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CELL_W-1:0]    cell_value,
	output logic [ROW_OUT_W-1:0] cursor_row_out,
	output logic [COL_OUT_W-1:0] cursor_col_out,
	input  logic                 cfg_wr_en,
	input  logic [COLOR_W-1:0]   cfg_wr_data
);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_FILL   = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]           state_q;
	logic [ADDR_W-1:0]    cnt_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic [COLOR_W-1:0]   text_color_q;
	logic                 out_valid_q;

	logic [CMD_W-1:0]     cmd_q;
	logic [CHAR_W-1:0]    ch_q;
	logic [INDEX_W-1:0]   index_q;
	cell_t                cell_value_q;
	logic [ROW_OUT_W-1:0] out_row_q;
	logic [COL_OUT_W-1:0] out_col_q;

	cell_t                screen_mem [CELL_COUNT];
	cell_t                rdata_q;
	logic                 mem_we;
	logic                 mem_re;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [ADDR_W-1:0]    mem_raddr;
	cell_t                mem_wdata;

	logic [ROW_W-1:0]     row_w;
	logic [COL_W-1:0]     col_w;
	logic                 wr_char;
	logic                 scroll_w;
	logic [ADDR_W-1:0]    cursor_addr;
	logic                 index_ok;
	logic                 out_free;
	logic                 put_now;
	logic                 exec_short;
	logic                 out_load;

	// cursor step for put character
	always_comb begin
		row_w   = row_q;
		col_w   = col_q;
		wr_char = 1'b0;
		if (ch_q == CHAR_LF) begin
			col_w = '0;
			row_w = row_q + 1'b1;
		end else if (ch_q == CHAR_CR) begin
			col_w = '0;
		end else if (ch_q == CHAR_TAB) begin
			col_w = (col_q + COL_W'(TAB_STOP)) & ~COL_W'(TAB_STOP - 1);
		end else if (ch_q >= SPACE_CHAR && ch_q <= CHAR_LAST) begin
			wr_char = 1'b1;
			col_w   = col_q + 1'b1;
		end
		if (col_w >= COL_W'(COLUMNS)) begin
			col_w = '0;
			row_w = row_w + 1'b1;
		end
		scroll_w = (row_w >= ROW_W'(ROWS));
		if (scroll_w) begin
			row_w = ROW_W'(ROWS - 1);
		end
	end

	assign cursor_addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign index_ok    = (32'(index_q) < CELL_COUNT);
	assign out_free    = !out_valid_q || !out_stall;
	assign put_now     = (state_q == ST_EXEC) && (cmd_q == CMD_PUT);
	assign exec_short  = (state_q == ST_EXEC) &&
		((put_now && !scroll_w) ||
		 (cmd_q != CMD_PUT && cmd_q != CMD_CLEAR && cmd_q != CMD_READ));
	assign out_load    = out_free && (exec_short || state_q == ST_DONE);

	// store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = {text_color_q, SPACE_CHAR};
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = {RESET_COLOR, SPACE_CHAR};
			end
			ST_EXEC: begin
				mem_we    = put_now && wr_char;
				mem_waddr = cursor_addr;
				mem_wdata = {text_color_q, ch_q};
			end
			ST_SCROLL: begin
				mem_we    = (cnt_q != '0);
				mem_waddr = cnt_q - 1'b1;
				mem_wdata = rdata_q;
			end
			ST_FILL: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_re = ((state_q == ST_EXEC) && (cmd_q == CMD_READ) && index_ok) ||
		((state_q == ST_SCROLL) && (cnt_q < ADDR_W'(SHIFT_COUNT)));
	assign mem_raddr = (state_q == ST_EXEC) ? ADDR_W'(index_q) : cnt_q + ADDR_W'(COLUMNS);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= screen_mem[mem_raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cnt_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			text_color_q <= RESET_COLOR;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				text_color_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd_q == CMD_PUT) begin
						row_q <= row_w;
						col_q <= col_w;
					end
					if (cmd_q == CMD_CLEAR) begin
						row_q   <= '0;
						col_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_FILL;
					end else if (put_now && scroll_w) begin
						cnt_q   <= '0;
						state_q <= ST_SCROLL;
					end else if (cmd_q == CMD_READ) begin
						state_q <= ST_DONE;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCROLL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(SHIFT_COUNT)) begin
						cnt_q   <= ADDR_W'(SHIFT_COUNT);
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	// beat payloads
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q   <= command;
			ch_q    <= char_code;
			index_q <= cell_index;
		end
		if (out_load) begin
			cell_value_q <= (state_q == ST_DONE && cmd_q == CMD_READ && index_ok) ?
				rdata_q : '0;
			out_row_q    <= put_now ? ROW_OUT_W'(row_w) : ROW_OUT_W'(row_q);
			out_col_q    <= put_now ? COL_OUT_W'(col_w) : COL_OUT_W'(col_q);
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign cell_value     = cell_value_q;
	assign cursor_row_out = out_row_q;
	assign cursor_col_out = out_col_q;

	`TCCW_ASSERT(a_cursor_bound, out_valid, (cursor_row_out < ROWS) && (cursor_col_out < COLUMNS), "cursor out of range")
	`TCCW_ASSERT(a_quiet_store, (state_q == ST_IDLE) || (state_q == ST_DONE), !mem_we, "store written while idle")
	`TCCW_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_q == ST_EXEC, "accepted beat not executed")
	`TCCW_ASSERT(a_scroll_span, state_q == ST_SCROLL, cnt_q <= ADDR_W'(SHIFT_COUNT), "scroll count overrun")

endmodule
